>>> src/blop_pkg.sv
package blop_pkg;

   localparam int DEF_MAX_STEPS = 1024;

   localparam logic [31:0] Q30_ONE = 32'h4000_0000;

   typedef enum logic [2:0] {
      CSR_UP_FACTOR   = 3'd0,
      CSR_DOWN_FACTOR = 3'd1,
      CSR_UP_WEIGHT   = 3'd2,
      CSR_DOWN_WEIGHT = 3'd3,
      CSR_INV_DISC    = 3'd4,
      CSR_NUM_STEPS   = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [31:0] up_factor;
      logic [31:0] down_factor;
      logic [30:0] up_weight;
      logic [30:0] down_weight;
      logic [30:0] inv_discount;
   } cfg_type;

   typedef struct packed {
      logic tab_go;
      logic tab_first;
      logic op_go;
      logic op_back;
   } ctl_type;

   // shift by 30, round half up, saturate to 32 bits
   function automatic logic [31:0] round_q30(input logic [63:0] p);
      logic [34:0] r;
      r = {1'b0, p[63:30]} + {34'd0, p[29]};
      return (r[34:32] != 3'd0) ? 32'hFFFF_FFFF : r[31:0];
   endfunction

   function automatic logic [31:0] payoff(input logic [31:0] spot,
                                          input logic [31:0] strike,
                                          input logic put);
      logic [31:0] res;
      if (put) begin
         res = (strike > spot) ? strike - spot : 32'd0;
      end else begin
         res = (spot > strike) ? spot - strike : 32'd0;
      end
      return res;
   endfunction

endpackage

>>> src/binomial_lattice_option_pricer_unit.sv
// Channel   Ports                                  Handshake
// request   req_stock_price req_strike_price       start & !busy accepts
//           req_is_put req_american
// result    rsp_option_price                       rsp_valid, one cycle
// config    csr_we csr_index csr_wdata             written when csr_we
//
// For N steps, one item runs from the accepting edge up to and including the result
// beat through: the table (N+1 entries, the up/down power recurrence), the leaves,
// the backward nodes through the lattice memory, a drain after the leaves and after
// each level, then the beat. Reset clears the sequencer and the pipeline valids
// and presets the config; memories are filled by each item before use.
// The result cannot be stalled; busy stays high until the result beat.
module binomial_lattice_option_pricer_unit #(
   parameter int MAX_STEPS = blop_pkg::DEF_MAX_STEPS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_stock_price,
   input  logic [31:0] req_strike_price,
   input  logic        req_is_put,
   input  logic        req_american,
   output logic        rsp_valid,
   output logic [31:0] rsp_option_price,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import blop_pkg::*;

   localparam int IW = $clog2(MAX_STEPS + 1);

   cfg_type     cfg_ff;
   logic [10:0] nsteps_ff;
   logic [31:0] spot_ff, strike_ff;
   logic        put_ff, amer_ff;
   logic [IW-1:0] n_clamp;
   ctl_type     ctl;
   logic [IW-1:0] tab_k, op_j, op_m;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_factor    <= Q30_ONE;
         cfg_ff.down_factor  <= Q30_ONE;
         cfg_ff.up_weight    <= 31'h2000_0000;
         cfg_ff.down_weight  <= 31'h2000_0000;
         cfg_ff.inv_discount <= 31'h4000_0000;
         nsteps_ff           <= 11'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UP_FACTOR:   cfg_ff.up_factor    <= csr_wdata;
            CSR_DOWN_FACTOR: cfg_ff.down_factor  <= csr_wdata;
            CSR_UP_WEIGHT:   cfg_ff.up_weight    <= csr_wdata[30:0];
            CSR_DOWN_WEIGHT: cfg_ff.down_weight  <= csr_wdata[30:0];
            CSR_INV_DISC:    cfg_ff.inv_discount <= csr_wdata[30:0];
            CSR_NUM_STEPS:   nsteps_ff           <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         spot_ff   <= req_stock_price;
         strike_ff <= req_strike_price;
         put_ff    <= req_is_put;
         amer_ff   <= req_american;
      end
   end

   assign n_clamp = ({21'd0, nsteps_ff} > 32'(MAX_STEPS)) ? IW'(MAX_STEPS)
                                                          : IW'(nsteps_ff);

   blop_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .n_steps (n_clamp),
      .ctl     (ctl),
      .tab_k   (tab_k),
      .op_j    (op_j),
      .op_m    (op_m),
      .busy    (busy),
      .done    (rsp_valid)
   );

   blop_core #(.MAX_STEPS(MAX_STEPS)) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .ctl    (ctl),
      .tab_k  (tab_k),
      .op_j   (op_j),
      .op_m   (op_m),
      .spot   (spot_ff),
      .strike (strike_ff),
      .put    (put_ff),
      .amer   (amer_ff),
      .result (rsp_option_price)
   );

endmodule

>>> src/blop_core.sv
module blop_core #(
   parameter int MAX_STEPS = blop_pkg::DEF_MAX_STEPS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  blop_pkg::cfg_type                cfg,
   input  blop_pkg::ctl_type                ctl,
   input  logic [$clog2(MAX_STEPS+1)-1:0]   tab_k,
   input  logic [$clog2(MAX_STEPS+1)-1:0]   op_j,
   input  logic [$clog2(MAX_STEPS+1)-1:0]   op_m,
   input  logic [31:0]                      spot,
   input  logic [31:0]                      strike,
   input  logic                             put,
   input  logic                             amer,
   output logic [31:0]                      result
);
   import blop_pkg::*;

   localparam int IW = $clog2(MAX_STEPS + 1);

   logic [31:0] su_mem  [0:MAX_STEPS];
   logic [31:0] dk_mem  [0:MAX_STEPS];
   logic [31:0] lat_mem [0:MAX_STEPS];

   // table recurrence
   logic [31:0] su_ff, dk_ff;
   logic [63:0] psu_ff, pdk_ff;
   logic        t1_ff;
   logic [IW-1:0] tk_ff;
   logic        tab_we;
   logic [IW-1:0] tab_addr;
   logic [31:0] su_in, dk_in;

   always_comb begin
      tab_we   = (ctl.tab_go && ctl.tab_first) || t1_ff;
      tab_addr = (ctl.tab_go && ctl.tab_first) ? '0 : tk_ff;
      su_in    = (ctl.tab_go && ctl.tab_first) ? spot : round_q30(psu_ff);
      dk_in    = (ctl.tab_go && ctl.tab_first) ? Q30_ONE : round_q30(pdk_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= 1'b0;
      end else begin
         t1_ff <= ctl.tab_go && !ctl.tab_first;
      end
      tk_ff  <= tab_k;
      psu_ff <= su_ff * cfg.up_factor;
      pdk_ff <= dk_ff * cfg.down_factor;
      if (tab_we) begin
         su_mem[tab_addr] <= su_in;
         dk_mem[tab_addr] <= dk_in;
         su_ff <= su_in;
         dk_ff <= dk_in;
      end
   end

   // node pipeline: read, multiply, sum and round, discount, write back
   logic [IW-1:0] jp1;
   assign jp1 = (op_j == IW'(MAX_STEPS)) ? op_j : op_j + 1'b1;

   logic [31:0] su_rd_ff, dk_rd_ff, l0_rd_ff, l1_rd_ff;
   logic        s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic        s1_b_ff, s2_b_ff, s3_b_ff, s4_b_ff;
   logic [IW-1:0] s1_j_ff, s2_j_ff, s3_j_ff, s4_j_ff;
   logic [63:0] psp_ff, plo_ff, phi_ff, pdis_ff;
   logic [31:0] e3_ff, e4_ff, v0_ff;
   logic [31:0] res_ff;
   logic [31:0] v_node, w_node;

   always_comb begin
      v_node = round_q30(pdis_ff);
      if (!s4_b_ff) begin
         w_node = e4_ff;
      end else if (amer && (e4_ff > v_node)) begin
         w_node = e4_ff;
      end else begin
         w_node = v_node;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= ctl.op_go;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
      su_rd_ff <= su_mem[op_j];
      dk_rd_ff <= dk_mem[op_m];
      l0_rd_ff <= lat_mem[op_j];
      l1_rd_ff <= lat_mem[jp1];
      s1_b_ff  <= ctl.op_back;
      s1_j_ff  <= op_j;
      psp_ff   <= su_rd_ff * dk_rd_ff;
      plo_ff   <= cfg.down_weight * l0_rd_ff;
      phi_ff   <= cfg.up_weight * l1_rd_ff;
      s2_b_ff  <= s1_b_ff;
      s2_j_ff  <= s1_j_ff;
      e3_ff    <= payoff(round_q30(psp_ff), strike, put);
      v0_ff    <= round_q30(plo_ff + phi_ff);
      s3_b_ff  <= s2_b_ff;
      s3_j_ff  <= s2_j_ff;
      pdis_ff  <= v0_ff * cfg.inv_discount;
      e4_ff    <= e3_ff;
      s4_b_ff  <= s3_b_ff;
      s4_j_ff  <= s3_j_ff;
      if (s4_v_ff) begin
         lat_mem[s4_j_ff] <= w_node;
         res_ff <= w_node;
      end
   end

   assign result = res_ff;

endmodule

>>> src/blop_ctrl.sv
module blop_ctrl #(
   parameter int MAX_STEPS = blop_pkg::DEF_MAX_STEPS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [$clog2(MAX_STEPS+1)-1:0]   n_steps,
   output blop_pkg::ctl_type                ctl,
   output logic [$clog2(MAX_STEPS+1)-1:0]   tab_k,
   output logic [$clog2(MAX_STEPS+1)-1:0]   op_j,
   output logic [$clog2(MAX_STEPS+1)-1:0]   op_m,
   output logic                             busy,
   output logic                             done
);
   import blop_pkg::*;

   localparam int IW = $clog2(MAX_STEPS + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_TABLE = 6'b000010,
      ST_LEAF  = 6'b000100,
      ST_BACK  = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   state_type   next_ff, next_in;
   logic [IW-1:0] n_ff, n_in, k_ff, k_in, j_ff, j_in, lvl_ff, lvl_in;
   logic        tog_ff, tog_in;
   logic [1:0]  dcnt_ff, dcnt_in;

   always_comb begin
      state_in = state_ff;
      next_in  = next_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      lvl_in   = lvl_ff;
      tog_in   = tog_ff;
      dcnt_in  = dcnt_ff;
      ctl      = '0;
      op_m     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in     = n_steps;
               k_in     = '0;
               tog_in   = 1'b0;
               state_in = ST_TABLE;
            end
         end
         ST_TABLE: begin
            ctl.tab_go    = !tog_ff;
            ctl.tab_first = (k_ff == '0);
            tog_in        = !tog_ff;
            if (tog_ff) begin
               if (k_ff == n_ff) begin
                  j_in     = '0;
                  state_in = ST_LEAF;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_LEAF: begin
            ctl.op_go = 1'b1;
            op_m      = n_ff - j_ff;
            if (j_ff == n_ff) begin
               dcnt_in  = '0;
               state_in = ST_DRAIN;
               if (n_ff == '0) begin
                  next_in = ST_DONE;
               end else begin
                  next_in = ST_BACK;
                  lvl_in  = n_ff - 1'b1;
                  j_in    = '0;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_BACK: begin
            ctl.op_go   = 1'b1;
            ctl.op_back = 1'b1;
            op_m        = lvl_ff - j_ff;
            if (j_ff == lvl_ff) begin
               dcnt_in  = '0;
               state_in = ST_DRAIN;
               if (lvl_ff == '0) begin
                  next_in = ST_DONE;
               end else begin
                  next_in = ST_BACK;
                  lvl_in  = lvl_ff - 1'b1;
                  j_in    = '0;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // hold until the last write of the level has landed
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 2'd3) begin
               state_in = next_ff;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         next_ff  <= ST_IDLE;
         n_ff     <= '0;
         k_ff     <= '0;
         j_ff     <= '0;
         lvl_ff   <= '0;
         tog_ff   <= 1'b0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         next_ff  <= next_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
         lvl_ff   <= lvl_in;
         tog_ff   <= tog_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   assign tab_k = k_ff;
   assign op_j  = j_ff;
   assign busy  = (state_ff != ST_IDLE);
   assign done  = (state_ff == ST_DONE);

`ifndef SYNTHESIS
   a_issue_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl.tab_go && ctl.op_go))
      else $error("table and node beats issued together");
   a_back_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.op_go && ctl.op_back) |-> (j_ff <= lvl_ff) && (lvl_ff < n_ff))
      else $error("backward node outside level");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> !busy)
      else $error("result strobe not followed by idle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy && !done)
      else $error("accepted item did not start work");
`endif

endmodule
